[rtl/core/kcv_pkg.sv]
// Shared types, constants and helpers for the constant-velocity Kalman filter core.
// Used by kcv_div, the top level and the checker. No dependencies.
`default_nettype none

package kcv_pkg;

    // Filter dimensions
    localparam int MEAS_DIM  = 2;
    localparam int STATE_DIM = 4;
    localparam bit RATIO     = (STATE_DIM == 2 * MEAS_DIM);
    localparam int NCOL      = MEAS_DIM + STATE_DIM;

    // Index widths
    localparam int XW = (STATE_DIM > 1) ? $clog2(STATE_DIM) : 1;
    localparam int MW = (MEAS_DIM > 1) ? $clog2(MEAS_DIM) : 1;
    localparam int CW = $clog2(NCOL);

    // Accumulator and divider sizes
    localparam int ACC_W = 52;
    localparam int DIV_N = 48;
    localparam int DCW   = $clog2(DIV_N);

    localparam logic signed [31:0] QONE = 32'sd65536;
    localparam logic [30:0] NOISE_RESET = 31'd65536;

    localparam logic signed [ACC_W-1:0] SAT_MAX = {{(ACC_W-32){1'b0}}, 32'h7fffffff};
    localparam logic signed [ACC_W-1:0] SAT_MIN = {{(ACC_W-32){1'b1}}, 32'h80000000};

    // Operation codes
    localparam logic [1:0] FUNC_PREDICT = 2'd0;
    localparam logic [1:0] FUNC_CORRECT = 2'd1;
    localparam logic [1:0] FUNC_RESTART = 2'd2;

    // Register indexes
    localparam logic [1:0] CFG_Q  = 2'd0;
    localparam logic [1:0] CFG_R  = 2'd1;
    localparam logic [1:0] CFG_P0 = 2'd2;

    typedef struct packed {
        logic [1:0]         func;
        logic signed [31:0] meas_0;
        logic signed [31:0] meas_1;
        logic signed [31:0] meas_2;
        logic signed [31:0] meas_3;
    } t_in;

    typedef struct packed {
        logic signed [31:0] est_0;
        logic signed [31:0] est_1;
        logic signed [31:0] est_2;
        logic signed [31:0] est_3;
        logic signed [31:0] est_4;
        logic signed [31:0] est_5;
        logic signed [31:0] est_6;
        logic signed [31:0] est_7;
        logic               singular;
        logic               saturated;
    } t_out;

    typedef struct packed {
        logic               start;
        logic signed [31:0] num;
        logic signed [31:0] den;
    } t_div_req;

    typedef struct packed {
        logic               done;
        logic signed [31:0] quo;
        logic               clip;
    } t_div_rsp;

    typedef struct packed {
        logic signed [31:0] val;
        logic               clip;
    } t_sat;

    // Clip a wide sum to 32-bit signed
    function automatic t_sat sat32(input logic signed [ACC_W-1:0] v);
        t_sat s;
        if (v > SAT_MAX) begin
            s.val  = 32'sh7fffffff;
            s.clip = 1'b1;
        end else if (v < SAT_MIN) begin
            s.val  = 32'sh80000000;
            s.clip = 1'b1;
        end else begin
            s.val  = v[31:0];
            s.clip = 1'b0;
        end
        return s;
    endfunction

endpackage

`default_nettype wire

[rtl/core/kcv_div.sv]
// Radix-2 restoring divider for Q16.16: (|a|<<16 + |b|/2) / |b|, signed, saturated.
// Works on one quotient at a time; a new start abandons the one in progress. Depends on kcv_pkg.
`default_nettype none

module kcv_div (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  kcv_pkg::t_div_req i_req,
    output kcv_pkg::t_div_rsp o_rsp
);
    import kcv_pkg::*;

    logic             r_busy;
    logic             r_done;
    logic             r_neg;
    logic [DCW-1:0]   r_cnt;
    logic [DIV_N-1:0] r_num;
    logic [DIV_N-1:0] r_quo;
    logic [31:0]      r_den;
    logic [31:0]      r_rem;

    logic [31:0] mag_a;
    logic [31:0] mag_b;
    logic [32:0] rem_sh;
    logic [32:0] rem_sub;
    logic        ge;
    logic signed [ACC_W-1:0] q_mag;
    logic signed [ACC_W-1:0] q_signed;
    t_sat q_sat;

    assign mag_a = i_req.num[31] ? (~i_req.num + 32'd1) : i_req.num;
    assign mag_b = i_req.den[31] ? (~i_req.den + 32'd1) : i_req.den;

    // One quotient bit per cycle
    assign rem_sh  = {r_rem, r_num[DIV_N-1]};
    assign ge      = (rem_sh >= {1'b0, r_den});
    assign rem_sub = rem_sh - {1'b0, r_den};

    assign q_mag    = $signed({{(ACC_W-DIV_N){1'b0}}, r_quo});
    assign q_signed = r_neg ? -q_mag : q_mag;
    assign q_sat    = sat32(q_signed);

    assign o_rsp.done = r_done;
    assign o_rsp.quo  = q_sat.val;
    assign o_rsp.clip = q_sat.clip;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
                r_num  <= DIV_N'({mag_a, 16'h0000}) + DIV_N'(mag_b >> 1);
                r_den  <= mag_b;
                r_rem  <= '0;
                r_quo  <= '0;
                r_neg  <= i_req.num[31] ^ i_req.den[31];
            end else if (r_busy) begin
                r_rem <= ge ? rem_sub[31:0] : rem_sh[31:0];
                r_num <= r_num << 1;
                r_quo <= {r_quo[DIV_N-2:0], ge};
                if (int'(r_cnt) == DIV_N - 1) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end else begin
                    r_cnt <= r_cnt + 1'b1;
                end
            end
        end
    end

endmodule

`default_nettype wire

[rtl/core/constant_velocity_kalman_filter_core.sv]
// Constant-velocity Kalman filter core: sequencer, state storage, shared multiplier.
// Depends on kcv_pkg and kcv_div.
//
// Usage:
//   Input channel (i_in_valid / o_in_ready / i_in_data) takes one item holding
//   an operation code and the measured positions. Output channel
//   (o_out_valid / i_out_ready / o_out_data) returns one item per input item:
//   the posterior state and the singular and saturated flags.
//   Configuration (i_cfg_we / i_cfg_idx / i_cfg_data) sets Q, R and the restart
//   covariance; write it only while the core is idle.
//   One item is in work at a time; o_in_ready is high only while idle.
//   Run time: restart and unused codes go straight to the output state; predict
//   is set by one accumulate step per matrix term; correct is set mostly by
//   the MEAS_DIM*(NCOL-1) serial divides in the Gauss-Jordan pass, then by
//   the multiply-accumulates through the registered shared multiplier.
//   A finished item waits in the output register; while the receiver stalls
//   a new item may be accepted and computed, and its result is held back
//   until the output register is free.
//   Reset (synchronous, active low) loads the default registers, zero state
//   and a unit posterior covariance.
`default_nettype none

module constant_velocity_kalman_filter_core (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    output logic          o_in_ready,
    input  kcv_pkg::t_in  i_in_data,
    output logic          o_out_valid,
    input  logic          i_out_ready,
    output kcv_pkg::t_out o_out_data,
    input  logic          i_cfg_we,
    input  logic [1:0]    i_cfg_idx,
    input  logic [30:0]   i_cfg_data
);
    import kcv_pkg::*;

    typedef enum logic [12:0] {
        S_IDLE  = 13'b0000000000001,
        S_PX    = 13'b0000000000010,
        S_PT1   = 13'b0000000000100,
        S_PP    = 13'b0000000001000,
        S_CAUG  = 13'b0000000010000,
        S_CPIV  = 13'b0000000100000,
        S_CSWAP = 13'b0000001000000,
        S_CDIV  = 13'b0000010000000,
        S_CELIM = 13'b0000100000000,
        S_CINN  = 13'b0001000000000,
        S_CX    = 13'b0010000000000,
        S_CP    = 13'b0100000000000,
        S_OUT   = 13'b1000000000000
    } t_state;

    // Rounded Q16.16 product, ties away from zero
    function automatic logic signed [ACC_W-1:0] roundq(input logic signed [63:0] p);
        logic [63:0] mag;
        logic [63:0] m;
        logic signed [ACC_W-1:0] s;
        mag = p[63] ? (~p + 64'd1) : p;
        m   = (mag + 64'd32768) >> 16;
        s   = $signed(m[ACC_W-1:0]);
        return p[63] ? -s : s;
    endfunction

    t_state r_state;

    logic [30:0] r_q;
    logic [30:0] r_r;
    logic [30:0] r_p0;

    logic signed [31:0] r_xp  [STATE_DIM];
    logic signed [31:0] r_xs  [STATE_DIM];
    logic signed [31:0] r_pp  [STATE_DIM][STATE_DIM];
    logic signed [31:0] r_ps  [STATE_DIM][STATE_DIM];
    logic signed [31:0] r_t1  [STATE_DIM][STATE_DIM];
    logic signed [31:0] r_aug [MEAS_DIM][NCOL];
    logic signed [31:0] r_inn [MEAS_DIM];
    logic signed [31:0] r_z   [MEAS_DIM];

    logic [XW-1:0] r_i;
    logic [CW-1:0] r_j;
    logic [MW-1:0] r_k;
    logic [MW-1:0] r_c;
    logic [MW-1:0] r_best;
    logic [1:0]    r_ph;

    logic signed [ACC_W-1:0] r_acc;
    logic signed [63:0]      r_prod;
    logic signed [31:0]      r_fac;
    logic signed [31:0]      r_piv;
    logic [31:0]             r_bm;
    logic                    r_clip;
    logic                    r_sing;
    logic                    r_ovalid;
    t_out                    r_out;

    logic in_acc;
    logic out_fire;

    logic [XW-1:0] ix_j;
    logic [XW-1:0] ix_k;
    logic [XW-1:0] ix_jm;
    logic [XW-1:0] i_plus_md;
    logic [XW-1:0] j_plus_md;
    logic [CW-1:0] col_mi;
    logic link_i, link_j, k_ok, j_lt_md, j_is_c, k_is_c;
    logic i_last, j_sd_last, j_col_last, k_last, c_last;

    logic signed [ACC_W-1:0] term;
    logic signed [ACC_W-1:0] n_acc;
    logic signed [ACC_W-1:0] q_ext;
    logic signed [ACC_W-1:0] r_ext;
    logic signed [ACC_W-1:0] rnd;
    logic signed [31:0]      mul_a;
    logic signed [31:0]      mul_b;
    logic                    elem_done;
    logic                    elim_row_end;
    t_sat                    sat_res;

    logic [31:0]   piv_mag;
    logic [31:0]   n_bm;
    logic [MW-1:0] n_best;

    logic signed [31:0] meas_arr [4];
    logic signed [31:0] est_arr  [8];

    t_div_req div_req;
    t_div_rsp div_rsp;

    kcv_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (div_req),
        .o_rsp   (div_rsp)
    );

    assign o_in_ready  = (r_state == S_IDLE);
    assign in_acc      = i_in_valid && o_in_ready;
    assign o_out_valid = r_ovalid;
    assign out_fire    = r_ovalid && i_out_ready;
    assign o_out_data  = r_out;

    assign meas_arr[0] = i_in_data.meas_0;
    assign meas_arr[1] = i_in_data.meas_1;
    assign meas_arr[2] = i_in_data.meas_2;
    assign meas_arr[3] = i_in_data.meas_3;

    // Index helpers
    assign ix_j       = r_j[XW-1:0];
    assign ix_k       = XW'(r_k);
    assign ix_jm      = XW'(r_j - CW'(MEAS_DIM));
    assign i_plus_md  = r_i + XW'(MEAS_DIM);
    assign j_plus_md  = ix_j + XW'(MEAS_DIM);
    assign col_mi     = CW'(MEAS_DIM) + CW'(r_i);
    assign link_i     = RATIO && (int'(r_i) < MEAS_DIM);
    assign link_j     = RATIO && (int'(r_j) < MEAS_DIM);
    assign k_ok       = (int'(r_k) < STATE_DIM);
    assign j_lt_md    = (int'(r_j) < MEAS_DIM);
    assign j_is_c     = (int'(r_j) == int'(r_c));
    assign k_is_c     = (r_k == r_c);
    assign i_last     = (int'(r_i) == STATE_DIM - 1);
    assign j_sd_last  = (int'(r_j) == STATE_DIM - 1);
    assign j_col_last = (int'(r_j) == NCOL - 1);
    assign k_last     = (int'(r_k) == MEAS_DIM - 1);
    assign c_last     = (int'(r_c) == MEAS_DIM - 1);

    assign q_ext = $signed({{(ACC_W-31){1'b0}}, r_q});
    assign r_ext = $signed({{(ACC_W-31){1'b0}}, r_r});
    assign rnd   = roundq(r_prod);

    // Term selection for the shared accumulator and multiplier
    always_comb begin
        term      = '0;
        elem_done = 1'b0;
        mul_a     = '0;
        mul_b     = '0;
        case (r_state)
            S_PX: begin
                term      = ACC_W'(r_xs[(r_ph == 2'd0) ? r_i : i_plus_md]);
                elem_done = (r_ph == 2'd1) || !link_i;
            end
            S_PT1: begin
                term      = ACC_W'(r_ps[(r_ph == 2'd0) ? r_i : i_plus_md][ix_j]);
                elem_done = (r_ph == 2'd1) || !link_i;
            end
            S_PP: begin
                if (r_ph == 2'd0) begin
                    term = (r_i == ix_j) ? q_ext : '0;
                end else begin
                    term = ACC_W'(r_t1[r_i][(r_ph == 2'd2) ? j_plus_md : ix_j]);
                end
                elem_done = (r_ph == 2'd2) || ((r_ph == 2'd1) && !link_j);
            end
            S_CAUG: begin
                if (r_ph == 2'd0) begin
                    if (k_ok && (!j_lt_md || (int'(r_j) < STATE_DIM))) begin
                        term = ACC_W'(r_pp[ix_k][j_lt_md ? ix_j : ix_jm]);
                    end
                end else begin
                    term = (int'(r_j) == int'(r_k)) ? r_ext : '0;
                end
                elem_done = (r_ph == 2'd1) || !j_lt_md;
            end
            S_CELIM: begin
                if (r_ph == 2'd0) begin
                    term = ACC_W'(r_aug[r_k][r_j]);
                end else if (r_ph == 2'd2) begin
                    term = -rnd;
                end
                mul_a = r_fac;
                mul_b = r_aug[r_c][r_j];
            end
            S_CINN: begin
                if (r_ph == 2'd0) begin
                    term = ACC_W'(r_z[r_k]);
                end else if (k_ok) begin
                    term = -ACC_W'(r_xp[ix_k]);
                end
                elem_done = (r_ph == 2'd1);
            end
            S_CX: begin
                if (r_ph == 2'd0) begin
                    term = ACC_W'(r_xp[r_i]);
                end else if (r_ph == 2'd2) begin
                    term = rnd;
                end
                mul_a = r_aug[r_k][col_mi];
                mul_b = r_inn[r_k];
            end
            S_CP: begin
                if (r_ph == 2'd0) begin
                    term = ACC_W'(r_pp[r_i][ix_j]);
                end else if (r_ph == 2'd2) begin
                    term = -rnd;
                end
                mul_a = r_aug[r_k][col_mi];
                mul_b = k_ok ? r_pp[ix_k][ix_j] : 32'sd0;
            end
            default: begin
                term = '0;
            end
        endcase
    end

    assign n_acc   = ((r_ph == 2'd0) ? ACC_W'(0) : r_acc) + term;
    assign sat_res = sat32(n_acc);

    // Pivot search compare
    assign piv_mag = r_aug[r_k][r_c][31] ? (~r_aug[r_k][r_c] + 32'd1) : r_aug[r_k][r_c];
    always_comb begin
        if (k_is_c || (piv_mag > r_bm)) begin
            n_bm   = piv_mag;
            n_best = r_k;
        end else begin
            n_bm   = r_bm;
            n_best = r_best;
        end
    end

    assign elim_row_end = k_is_c ||
                          (j_col_last && ((j_is_c && (r_ph == 2'd0)) || (r_ph == 2'd2)));

    // Divider request
    assign div_req.start = (r_state == S_CDIV) && (r_ph == 2'd0) && !j_is_c;
    assign div_req.num   = r_aug[r_c][r_j];
    assign div_req.den   = r_piv;

    // Posterior state to the output fields
    always_comb begin
        for (int k = 0; k < 8; k++) begin
            if (k < STATE_DIM) begin
                est_arr[k] = r_xs[XW'(k)];
            end else begin
                est_arr[k] = 32'sd0;
            end
        end
    end

    // Shared multiplier, registered
    always_ff @(posedge i_clk) begin
        r_prod <= mul_a * mul_b;
    end

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_q  <= NOISE_RESET;
            r_r  <= NOISE_RESET;
            r_p0 <= NOISE_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_Q:   r_q  <= i_cfg_data;
                CFG_R:   r_r  <= i_cfg_data;
                CFG_P0:  r_p0 <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Sequencer and state storage
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_ovalid <= 1'b0;
            r_clip   <= 1'b0;
            r_sing   <= 1'b0;
            r_i      <= '0;
            r_j      <= '0;
            r_k      <= '0;
            r_c      <= '0;
            r_ph     <= '0;
            for (int a = 0; a < STATE_DIM; a++) begin
                r_xp[a] <= '0;
                r_xs[a] <= '0;
                for (int b = 0; b < STATE_DIM; b++) begin
                    r_pp[a][b] <= '0;
                    r_ps[a][b] <= (a == b) ? QONE : 32'sd0;
                end
            end
        end else begin
            if (out_fire) begin
                r_ovalid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (in_acc) begin
                        r_clip <= 1'b0;
                        r_sing <= 1'b0;
                        r_i    <= '0;
                        r_j    <= '0;
                        r_k    <= '0;
                        r_c    <= '0;
                        r_ph   <= '0;
                        for (int k = 0; k < MEAS_DIM; k++) begin
                            r_z[k] <= meas_arr[k];
                        end
                        case (i_in_data.func)
                            FUNC_PREDICT: r_state <= S_PX;
                            FUNC_CORRECT: r_state <= S_CAUG;
                            FUNC_RESTART: begin
                                for (int a = 0; a < STATE_DIM; a++) begin
                                    r_xp[a] <= '0;
                                    r_xs[a] <= '0;
                                    for (int b = 0; b < STATE_DIM; b++) begin
                                        r_pp[a][b] <= '0;
                                        r_ps[a][b] <= (a == b) ? $signed({1'b0, r_p0})
                                                               : 32'sd0;
                                    end
                                end
                                r_state <= S_OUT;
                            end
                            default: r_state <= S_OUT;
                        endcase
                    end
                end

                // x' = A*x, written to both state vectors
                S_PX: begin
                    r_acc <= n_acc;
                    if (elem_done) begin
                        r_xp[r_i] <= sat_res.val;
                        r_xs[r_i] <= sat_res.val;
                        r_clip    <= r_clip | sat_res.clip;
                        r_ph      <= '0;
                        if (i_last) begin
                            r_i     <= '0;
                            r_j     <= '0;
                            r_state <= S_PT1;
                        end else begin
                            r_i <= r_i + 1'b1;
                        end
                    end else begin
                        r_ph <= r_ph + 1'b1;
                    end
                end

                // A*P
                S_PT1: begin
                    r_acc <= n_acc;
                    if (elem_done) begin
                        r_t1[r_i][ix_j] <= sat_res.val;
                        r_clip          <= r_clip | sat_res.clip;
                        r_ph            <= '0;
                        if (j_sd_last) begin
                            r_j <= '0;
                            if (i_last) begin
                                r_i     <= '0;
                                r_state <= S_PP;
                            end else begin
                                r_i <= r_i + 1'b1;
                            end
                        end else begin
                            r_j <= r_j + 1'b1;
                        end
                    end else begin
                        r_ph <= r_ph + 1'b1;
                    end
                end

                // (A*P)*At + Q, written to both covariances
                S_PP: begin
                    r_acc <= n_acc;
                    if (elem_done) begin
                        r_pp[r_i][ix_j] <= sat_res.val;
                        r_ps[r_i][ix_j] <= sat_res.val;
                        r_clip          <= r_clip | sat_res.clip;
                        r_ph            <= '0;
                        if (j_sd_last) begin
                            r_j <= '0;
                            if (i_last) begin
                                r_i     <= '0;
                                r_state <= S_OUT;
                            end else begin
                                r_i <= r_i + 1'b1;
                            end
                        end else begin
                            r_j <= r_j + 1'b1;
                        end
                    end else begin
                        r_ph <= r_ph + 1'b1;
                    end
                end

                // Augmented matrix [S | H*P']
                S_CAUG: begin
                    r_acc <= n_acc;
                    if (elem_done) begin
                        r_aug[r_k][r_j] <= sat_res.val;
                        r_clip          <= r_clip | sat_res.clip;
                        r_ph            <= '0;
                        if (j_col_last) begin
                            r_j <= '0;
                            if (k_last) begin
                                r_k     <= '0;
                                r_c     <= '0;
                                r_state <= S_CPIV;
                            end else begin
                                r_k <= r_k + 1'b1;
                            end
                        end else begin
                            r_j <= r_j + 1'b1;
                        end
                    end else begin
                        r_ph <= r_ph + 1'b1;
                    end
                end

                // Largest magnitude in column c, first one wins ties
                S_CPIV: begin
                    r_bm   <= n_bm;
                    r_best <= n_best;
                    if (k_last) begin
                        if (n_bm == 32'd0) begin
                            r_sing  <= 1'b1;
                            r_clip  <= 1'b0;
                            r_state <= S_OUT;
                        end else begin
                            r_state <= S_CSWAP;
                        end
                    end else begin
                        r_k <= r_k + 1'b1;
                    end
                end

                S_CSWAP: begin
                    if (r_best != r_c) begin
                        for (int b = 0; b < NCOL; b++) begin
                            r_aug[r_c][b]    <= r_aug[r_best][b];
                            r_aug[r_best][b] <= r_aug[r_c][b];
                        end
                    end
                    r_piv   <= r_aug[r_best][r_c];
                    r_j     <= '0;
                    r_ph    <= '0;
                    r_state <= S_CDIV;
                end

                // Normalize the pivot row
                S_CDIV: begin
                    if (j_is_c || ((r_ph == 2'd1) && div_rsp.done)) begin
                        if (j_is_c) begin
                            r_aug[r_c][r_j] <= QONE;
                        end else begin
                            r_aug[r_c][r_j] <= div_rsp.quo;
                            r_clip          <= r_clip | div_rsp.clip;
                        end
                        r_ph <= '0;
                        if (j_col_last) begin
                            r_j     <= '0;
                            r_k     <= '0;
                            r_state <= S_CELIM;
                        end else begin
                            r_j <= r_j + 1'b1;
                        end
                    end else if (r_ph == 2'd0) begin
                        r_ph <= 2'd1;
                    end
                end

                // Clear column c in the other rows
                S_CELIM: begin
                    if ((r_j == '0) && (r_ph == 2'd0)) begin
                        r_fac <= r_aug[r_k][r_c];
                    end
                    if (!k_is_c) begin
                        if (j_is_c && (r_ph == 2'd0)) begin
                            r_aug[r_k][r_j] <= '0;
                            if (!j_col_last) begin
                                r_j <= r_j + 1'b1;
                            end
                        end else if (r_ph == 2'd0) begin
                            r_acc <= n_acc;
                            r_ph  <= 2'd1;
                        end else if (r_ph == 2'd1) begin
                            r_ph <= 2'd2;
                        end else begin
                            r_aug[r_k][r_j] <= sat_res.val;
                            r_clip          <= r_clip | sat_res.clip;
                            r_ph            <= '0;
                            if (!j_col_last) begin
                                r_j <= r_j + 1'b1;
                            end
                        end
                    end
                    if (elim_row_end) begin
                        r_j  <= '0;
                        r_ph <= '0;
                        if (k_last) begin
                            if (c_last) begin
                                r_k     <= '0;
                                r_state <= S_CINN;
                            end else begin
                                r_c     <= r_c + 1'b1;
                                r_k     <= r_c + 1'b1;
                                r_state <= S_CPIV;
                            end
                        end else begin
                            r_k <= r_k + 1'b1;
                        end
                    end
                end

                // Innovation z - H*x'
                S_CINN: begin
                    r_acc <= n_acc;
                    if (elem_done) begin
                        r_inn[r_k] <= sat_res.val;
                        r_clip     <= r_clip | sat_res.clip;
                        r_ph       <= '0;
                        if (k_last) begin
                            r_k     <= '0;
                            r_i     <= '0;
                            r_state <= S_CX;
                        end else begin
                            r_k <= r_k + 1'b1;
                        end
                    end else begin
                        r_ph <= r_ph + 1'b1;
                    end
                end

                // x = x' + K*innovation
                S_CX: begin
                    if (r_ph == 2'd1) begin
                        r_ph <= 2'd2;
                    end else begin
                        r_acc <= n_acc;
                        if (r_ph == 2'd0) begin
                            r_ph <= 2'd1;
                        end else if (k_last) begin
                            r_xs[r_i] <= sat_res.val;
                            r_clip    <= r_clip | sat_res.clip;
                            r_k       <= '0;
                            r_ph      <= '0;
                            if (i_last) begin
                                r_i     <= '0;
                                r_j     <= '0;
                                r_state <= S_CP;
                            end else begin
                                r_i <= r_i + 1'b1;
                            end
                        end else begin
                            r_k  <= r_k + 1'b1;
                            r_ph <= 2'd1;
                        end
                    end
                end

                // P = P' - K*H*P'
                S_CP: begin
                    if (r_ph == 2'd1) begin
                        r_ph <= 2'd2;
                    end else begin
                        r_acc <= n_acc;
                        if (r_ph == 2'd0) begin
                            r_ph <= 2'd1;
                        end else if (k_last) begin
                            r_ps[r_i][ix_j] <= sat_res.val;
                            r_clip          <= r_clip | sat_res.clip;
                            r_k             <= '0;
                            r_ph            <= '0;
                            if (j_sd_last) begin
                                r_j <= '0;
                                if (i_last) begin
                                    r_i     <= '0;
                                    r_state <= S_OUT;
                                end else begin
                                    r_i <= r_i + 1'b1;
                                end
                            end else begin
                                r_j <= r_j + 1'b1;
                            end
                        end else begin
                            r_k  <= r_k + 1'b1;
                            r_ph <= 2'd1;
                        end
                    end
                end

                // Hand the item to the output register once it is free
                S_OUT: begin
                    if (!r_ovalid || i_out_ready) begin
                        r_out.est_0     <= est_arr[0];
                        r_out.est_1     <= est_arr[1];
                        r_out.est_2     <= est_arr[2];
                        r_out.est_3     <= est_arr[3];
                        r_out.est_4     <= est_arr[4];
                        r_out.est_5     <= est_arr[5];
                        r_out.est_6     <= est_arr[6];
                        r_out.est_7     <= est_arr[7];
                        r_out.singular  <= r_sing;
                        r_out.saturated <= r_clip;
                        r_ovalid        <= 1'b1;
                        r_state         <= S_IDLE;
                    end
                end

                default: r_state <= S_IDLE;
            endcase
        end
    end

endmodule

`default_nettype wire

[rtl/core/kcv_chk.sv]
// Port-level checker for the Kalman filter core, bound to the top level.
// Depends on kcv_pkg.
`default_nettype none

module kcv_chk (
    input logic          i_clk,
    input logic          i_rst_n,
    input logic          i_in_valid,
    input logic          o_in_ready,
    input kcv_pkg::t_in  i_in_data,
    input logic          o_out_valid,
    input logic          i_out_ready,
    input kcv_pkg::t_out o_out_data,
    input logic          i_cfg_we,
    input logic [1:0]    i_cfg_idx,
    input logic [30:0]   i_cfg_data
);
    import kcv_pkg::*;

    // One item in work at a time
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |=> !o_in_ready)
        else $error("core ready right after accepting an item");

    // A correct item keeps the core busy after acceptance
    a_correct_takes_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready && (i_in_data.func == FUNC_CORRECT))
        |=> !o_in_ready ##1 !o_in_ready)
        else $error("correct item finished too early");

    // A skipped correction reports no clipping
    a_flags_exclusive: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> !(o_out_data.singular && o_out_data.saturated))
        else $error("singular and saturated both set");

    // Stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !i_out_ready) |=> (o_out_valid && $stable(o_out_data)))
        else $error("output item changed while stalled");

endmodule

bind constant_velocity_kalman_filter_core kcv_chk u_kcv_chk (.*);

`default_nettype wire
